@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files.
// Each macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge.
`define CWO_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// The condition must never be true at a sampled edge.
`define CWO_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

@@ rtl/cwo_pkg.sv @@
package cwo_pkg;

   // Field and register widths.
   localparam int OFFSET_W = 12;
   localparam int HEIGHT_W = 11;
   localparam int COUNT_W  = 10;
   localparam int STEP_W   = 11;
   localparam int MODE_W   = 2;
   localparam int COLUMN_W = 9;
   localparam int ROW_W    = 10;
   localparam int RANDOM_W = 8;
   localparam int INDEX_W  = 2;

   // Item modes.
   localparam logic [MODE_W-1:0] MODE_SEED   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TICK   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

   // Register indexes of the configuration port.
   localparam logic [INDEX_W-1:0] CSR_SCREEN_HEIGHT = 2'd0;
   localparam logic [INDEX_W-1:0] CSR_COLUMN_COUNT  = 2'd1;
   localparam logic [INDEX_W-1:0] CSR_FAST_STEP     = 2'd2;

   // Reset values of the registers.
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 11'd200;
   localparam logic [COUNT_W-1:0]  COUNT_RESET  = 10'd160;
   localparam logic [STEP_W-1:0]   STEP_RESET   = 11'd8;

   // Offsets below this value grow by offset plus one per tick.
   localparam logic [OFFSET_W-1:0] SLOW_LIMIT = 12'd16;

   // Seed offsets are kept between this value and zero.
   localparam logic signed [OFFSET_W:0] SEED_MIN = -13'sd15;

   typedef logic signed [OFFSET_W-1:0] offset_type;

   // Result of one column update during a tick.
   typedef struct packed {
      logic       moved;
      offset_type offset;
   } fall_type;

endpackage

@@ rtl/cwo_cell.sv @@
// One column offset in the rotating ring.
module cwo_cell (
   input  logic               clock,
   input  logic               shift_en,
   input  logic               load_en,
   input  cwo_pkg::offset_type load_value,
   input  cwo_pkg::offset_type next_value,
   output cwo_pkg::offset_type value
);

   cwo_pkg::offset_type value_ff;
   cwo_pkg::offset_type value_in;

   // A load takes priority over a shift from the neighbor.
   always_comb begin
      value_in = value_ff;
      priority if (load_en) begin
         value_in = load_value;
      end else if (shift_en) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

@@ rtl/cwo_fall.sv @@
// Update of one column offset for a tick.
module cwo_fall (
   input  cwo_pkg::offset_type          offset,
   input  logic [cwo_pkg::HEIGHT_W-1:0] height,
   input  logic [cwo_pkg::STEP_W-1:0]   fast_step,
   output cwo_pkg::fall_type            result
);

   logic [cwo_pkg::HEIGHT_W-1:0] magnitude;
   logic [cwo_pkg::HEIGHT_W:0]   drop;
   logic [cwo_pkg::HEIGHT_W+1:0] landed;

   // A non-negative offset below the height fits in the height width.
   assign magnitude = offset[cwo_pkg::HEIGHT_W-1:0];
   assign drop = (offset < $signed(cwo_pkg::SLOW_LIMIT))
               ? {1'b0, magnitude} + 12'd1
               : {1'b0, fast_step};
   assign landed = {2'b00, magnitude} + {1'b0, drop};

   always_comb begin
      result.moved  = 1'b0;
      result.offset = offset;
      priority if (offset[cwo_pkg::OFFSET_W-1]) begin
         // Column still waiting: count up toward zero.
         result.moved  = 1'b1;
         result.offset = offset + 12'sd1;
      end else if (magnitude < height) begin
         // Column falling: step down, never past the bottom row.
         result.moved = 1'b1;
         if (landed >= {2'b00, height}) begin
            result.offset = $signed({1'b0, height});
         end else begin
            result.offset = $signed({1'b0, landed[cwo_pkg::HEIGHT_W-1:0]});
         end
      end
   end

endmodule

@@ rtl/column_melt_wipe_offsets.sv @@
// Latency: mode 3 items, lookups at rows at or beyond the height, and seeds or lookups for a
// column at or above MAX_COLUMNS give rsp_valid in the cycle after acceptance.
// Other seeds and lookups are answered once the offset ring, which rotates one cell per cycle, has
// brought the wanted column to the head; a tick turns the ring through every cell once.
// One item is worked on at a time; busy is high until its result is issued, no stall.
// Reset (synchronous) restores the registers and clears the last seed; offsets stay undefined.
`include "assert_macros.svh"

module column_melt_wipe_offsets #(
   parameter int MAX_COLUMNS = 512
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [cwo_pkg::MODE_W-1:0]    req_mode,
   input  logic [cwo_pkg::COLUMN_W-1:0]  req_column,
   input  logic [cwo_pkg::ROW_W-1:0]     req_row,
   input  logic [cwo_pkg::RANDOM_W-1:0]  req_random_value,
   output logic                          rsp_valid,
   output logic                          rsp_source_is_end,
   output logic [cwo_pkg::ROW_W-1:0]     rsp_source_row,
   output logic                          rsp_melt_done,
   input  logic                          csr_we,
   input  logic [cwo_pkg::INDEX_W-1:0]   csr_index,
   input  logic [cwo_pkg::HEIGHT_W-1:0]  csr_wdata
);

   localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam logic [CW-1:0] LAST = CW'(MAX_COLUMNS - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SEEK = 2'd1;
   localparam logic [1:0] ST_TICK = 2'd2;

   // Residue modulo 3 of a byte from sums of base-4 digits.
   function automatic logic [1:0] mod3(input logic [7:0] x);
      logic [3:0] s;
      logic [2:0] t;
      logic [1:0] r;
      s = {2'b00, x[7:6]} + {2'b00, x[5:4]} + {2'b00, x[3:2]} + {2'b00, x[1:0]};
      t = {1'b0, s[3:2]} + {1'b0, s[1:0]};
      unique case (t)
         3'd1, 3'd4: r = 2'd1;
         3'd2, 3'd5: r = 2'd2;
         default:    r = 2'd0;
      endcase
      return r;
   endfunction

   logic [1:0]                    state_ff, state_in;
   logic [CW-1:0]                 head_ff, head_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic                          moved_ff, moved_in;
   cwo_pkg::offset_type           prev_ff, prev_in;
   logic [cwo_pkg::HEIGHT_W-1:0]  height_ff, height_in;
   logic [cwo_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [cwo_pkg::STEP_W-1:0]    step_ff, step_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic [CW-1:0]                 target_ff, target_in;
   logic                          is_seed_ff, is_seed_in;
   logic [cwo_pkg::ROW_W-1:0]     row_ff, row_in;
   cwo_pkg::offset_type           seed_ff, seed_in;
   logic                          rsp_end_ff, rsp_end_in;
   logic [cwo_pkg::ROW_W-1:0]     rsp_row_ff, rsp_row_in;
   logic                          rsp_done_ff, rsp_done_in;

   logic                          accept;
   logic                          column_out;
   logic                          row_out;
   logic [CW-1:0]                 head_next;
   logic                          shift_en;
   logic                          load_en;
   logic                          tick_active;
   cwo_pkg::offset_type           tail_value;
   cwo_pkg::offset_type           head_value;
   cwo_pkg::fall_type             fall;
   cwo_pkg::offset_type           cell_value [MAX_COLUMNS];

   logic [1:0]                    rnd_mod3;
   logic signed [cwo_pkg::OFFSET_W:0] seed_step;
   cwo_pkg::offset_type           seed_value;
   logic signed [cwo_pkg::OFFSET_W:0] row_signed;
   logic signed [cwo_pkg::OFFSET_W:0] base;
   logic signed [cwo_pkg::OFFSET_W:0] start_row;

   assign accept     = start && !busy;
   assign busy       = (state_ff != ST_IDLE);
   assign column_out = (32'(req_column) >= 32'(MAX_COLUMNS));
   assign row_out    = ({1'b0, req_row} >= height_ff);
   assign head_next  = (head_ff == LAST) ? '0 : head_ff + 1'b1;
   assign head_value = cell_value[0];

   // Seed offset: first column from the low nibble, later ones walk from the last seed.
   assign rnd_mod3  = mod3(req_random_value);
   assign seed_step = $signed({prev_ff[cwo_pkg::OFFSET_W-1], prev_ff})
                    + $signed({11'd0, rnd_mod3}) - 13'sd1;
   always_comb begin
      if (req_column == '0) begin
         seed_value = -$signed({8'd0, req_random_value[3:0]});
      end else begin
         priority if (seed_step > 13'sd0) begin
            seed_value = '0;
         end else if (seed_step < cwo_pkg::SEED_MIN) begin
            seed_value = cwo_pkg::SEED_MIN[cwo_pkg::OFFSET_W-1:0];
         end else begin
            seed_value = seed_step[cwo_pkg::OFFSET_W-1:0];
         end
      end
   end

   // Lookup answer from the offset at the ring head.
   assign row_signed = $signed({3'b000, row_ff});
   assign base       = head_value[cwo_pkg::OFFSET_W-1] ? '0
                     : $signed({head_value[cwo_pkg::OFFSET_W-1], head_value});
   assign start_row  = row_signed - base;

   // Tick update on the path from the head back to the tail.
   cwo_fall u_fall (
      .offset    (head_value),
      .height    (height_ff),
      .fast_step (step_ff),
      .result    (fall)
   );

   assign tail_value = tick_active ? fall.offset : head_value;

   // Ring of offset cells: each shift moves the head column to the tail.
   for (genvar gi = 0; gi < MAX_COLUMNS; gi++) begin : g_cell
      if (gi == MAX_COLUMNS - 1) begin : g_tail
         if (gi == 0) begin : g_only
            cwo_cell u_cell (
               .clock      (clock),
               .shift_en   (shift_en),
               .load_en    (load_en),
               .load_value (seed_ff),
               .next_value (tail_value),
               .value      (cell_value[gi])
            );
         end else begin : g_last
            cwo_cell u_cell (
               .clock      (clock),
               .shift_en   (shift_en),
               .load_en    (1'b0),
               .load_value (seed_ff),
               .next_value (tail_value),
               .value      (cell_value[gi])
            );
         end
      end else if (gi == 0) begin : g_head
         cwo_cell u_cell (
            .clock      (clock),
            .shift_en   (shift_en),
            .load_en    (load_en),
            .load_value (seed_ff),
            .next_value (cell_value[gi+1]),
            .value      (cell_value[gi])
         );
      end else begin : g_mid
         cwo_cell u_cell (
            .clock      (clock),
            .shift_en   (shift_en),
            .load_en    (1'b0),
            .load_value (seed_ff),
            .next_value (cell_value[gi+1]),
            .value      (cell_value[gi])
         );
      end
   end

   // Sequencer and configuration registers.
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      cnt_in       = cnt_ff;
      moved_in     = moved_ff;
      prev_in      = prev_ff;
      height_in    = height_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      target_in    = target_ff;
      is_seed_in   = is_seed_ff;
      row_in       = row_ff;
      seed_in      = seed_ff;
      rsp_valid_in = 1'b0;
      rsp_end_in   = 1'b0;
      rsp_row_in   = '0;
      rsp_done_in  = 1'b0;
      shift_en     = 1'b0;
      load_en      = 1'b0;
      tick_active  = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            cwo_pkg::CSR_SCREEN_HEIGHT: height_in = csr_wdata;
            cwo_pkg::CSR_COLUMN_COUNT:  count_in  = csr_wdata[cwo_pkg::COUNT_W-1:0];
            cwo_pkg::CSR_FAST_STEP:     step_in   = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_mode)
                  cwo_pkg::MODE_SEED: begin
                     prev_in = seed_value;
                     if (column_out) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        target_in  = CW'(req_column);
                        seed_in    = seed_value;
                        is_seed_in = 1'b1;
                        state_in   = ST_SEEK;
                     end
                  end
                  cwo_pkg::MODE_TICK: begin
                     cnt_in   = '0;
                     moved_in = 1'b0;
                     state_in = ST_TICK;
                  end
                  cwo_pkg::MODE_LOOKUP: begin
                     if (row_out || column_out) begin
                        rsp_valid_in = 1'b1;
                        rsp_end_in   = 1'b1;
                        rsp_row_in   = req_row;
                     end else begin
                        target_in  = CW'(req_column);
                        row_in     = req_row;
                        is_seed_in = 1'b0;
                        state_in   = ST_SEEK;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SEEK: begin
            if (head_ff == target_ff) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (is_seed_ff) begin
                  load_en = 1'b1;
               end else if (row_signed < $signed({head_value[cwo_pkg::OFFSET_W-1],
                                                   head_value})) begin
                  rsp_end_in = 1'b1;
                  rsp_row_in = row_ff;
               end else begin
                  rsp_row_in = start_row[cwo_pkg::ROW_W-1:0];
               end
            end else begin
               shift_en = 1'b1;
               head_in  = head_next;
            end
         end
         ST_TICK: begin
            // One full turn of the ring; only columns in use are updated.
            shift_en    = 1'b1;
            tick_active = (32'(head_ff) < 32'(count_ff));
            head_in     = head_next;
            cnt_in      = cnt_ff + 1'b1;
            moved_in    = moved_ff || (tick_active && fall.moved);
            if (cnt_ff == LAST) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_done_in  = !moved_in;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         cnt_ff       <= '0;
         moved_ff     <= 1'b0;
         prev_ff      <= '0;
         height_ff    <= cwo_pkg::HEIGHT_RESET;
         count_ff     <= cwo_pkg::COUNT_RESET;
         step_ff      <= cwo_pkg::STEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         cnt_ff       <= cnt_in;
         moved_ff     <= moved_in;
         prev_ff      <= prev_in;
         height_ff    <= height_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item and result payload.
   always_ff @(posedge clock) begin
      target_ff   <= target_in;
      is_seed_ff  <= is_seed_in;
      row_ff      <= row_in;
      seed_ff     <= seed_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_source_is_end = rsp_end_ff;
   assign rsp_source_row    = rsp_row_ff;
   assign rsp_melt_done     = rsp_done_ff;

   // A result follows either an accepted item or a cycle of work on one.
   `CWO_ASSERT(a_rsp_cause, rsp_valid_ff |-> ($past(accept) || $past(state_ff != ST_IDLE)), "result without an item")
   // The ring head always names a stored column.
   `CWO_NEVER(a_head_range, head_ff > LAST, "ring head beyond the last column")
   // The last step of a tick issues its result and frees the block.
   `CWO_ASSERT(a_tick_end, (state_ff == ST_TICK && cnt_ff == LAST) |=> (rsp_valid_ff && !busy), "tick did not finish")
   // A load of a seed happens only when the head has reached the wanted column.
   `CWO_ASSERT(a_load_head, load_en |-> (state_ff == ST_SEEK && head_ff == target_ff), "seed stored at the wrong column")

endmodule

@@ dv/tb_column_melt_wipe_offsets.sv @@
`timescale 1ns / 1ps

module tb_column_melt_wipe_offsets;

   localparam int COLUMN_SLOTS  = 512;
   localparam int ROW_MAX       = (1 << cwo_pkg::ROW_W) - 1;
   localparam int SLOW_ROWS     = 16;
   localparam int SEED_FLOOR    = -15;
   localparam int SEED_SPREAD   = 16;
   localparam int SEED_STEPS    = 3;
   localparam int HEIGHT_TOP    = 1024;
   localparam int STEP_TOP      = 1024;
   localparam int DEFAULT_H     = 200;
   localparam int DEFAULT_N     = 160;
   localparam int DEFAULT_STEP  = 8;
   localparam int RANDOM_ITEMS  = 450;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 2 * COLUMN_SLOTS + 8;
   localparam int CYCLE_LIMIT   = 4000000;
   localparam int REPORT_LIMIT  = 100;

   // Mode code that the block must ignore.
   localparam logic [cwo_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

   // One expected answer of the block.
   typedef struct packed {
      logic                      is_end;
      logic [cwo_pkg::ROW_W-1:0] src_row;
      logic                      melt_done;
   } melt_answer_type;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic [cwo_pkg::MODE_W-1:0]   req_mode;
   logic [cwo_pkg::COLUMN_W-1:0] req_column;
   logic [cwo_pkg::ROW_W-1:0]    req_row;
   logic [cwo_pkg::RANDOM_W-1:0] req_random_value;
   logic                         rsp_valid;
   logic                         rsp_source_is_end;
   logic [cwo_pkg::ROW_W-1:0]    rsp_source_row;
   logic                         rsp_melt_done;
   logic                         csr_we;
   logic [cwo_pkg::INDEX_W-1:0]  csr_index;
   logic [cwo_pkg::HEIGHT_W-1:0] csr_wdata;

   // Predicted state of the offset engine.
   cwo_pkg::offset_type          column_drop [COLUMN_SLOTS];
   cwo_pkg::offset_type          last_seed;
   logic [cwo_pkg::HEIGHT_W-1:0] model_height;
   logic [cwo_pkg::COUNT_W-1:0]  model_count;
   logic [cwo_pkg::STEP_W-1:0]   model_step;

   melt_answer_type answers_due[$];
   logic            melt_finished;
   int              items_sent;
   int              burst_left;
   int              errors;
   int              cycles;

   column_melt_wipe_offsets #(
      .MAX_COLUMNS(COLUMN_SLOTS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_column(req_column),
      .req_row(req_row),
      .req_random_value(req_random_value),
      .rsp_valid(rsp_valid),
      .rsp_source_is_end(rsp_source_is_end),
      .rsp_source_row(rsp_source_row),
      .rsp_melt_done(rsp_melt_done),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Applies one item to the predicted state and returns the answer it must give.
   function automatic melt_answer_type advance_melt(input logic [cwo_pkg::MODE_W-1:0] mode,
         input logic [cwo_pkg::COLUMN_W-1:0] col, input logic [cwo_pkg::ROW_W-1:0] row,
         input logic [cwo_pkg::RANDOM_W-1:0] rnd);
      melt_answer_type ans;
      int v;
      int o;
      int dy;
      int n;
      int h;
      logic moved;
      ans = '0;
      h = int'(model_height);
      case (mode)
         cwo_pkg::MODE_SEED: begin
            // Column 0 starts a new chain; later columns wander from the previous one.
            if (col == '0) begin
               v = -int'(rnd % SEED_SPREAD);
            end else begin
               v = int'(last_seed) + int'(rnd % SEED_STEPS) - 1;
               if (v > 0) v = 0;
               if (v < SEED_FLOOR) v = SEED_FLOOR;
            end
            column_drop[col] = cwo_pkg::offset_type'(v);
            last_seed = cwo_pkg::offset_type'(v);
         end
         cwo_pkg::MODE_TICK: begin
            n = int'(model_count);
            if (n > COLUMN_SLOTS) n = COLUMN_SLOTS;
            moved = 1'b0;
            for (int i = 0; i < n; i++) begin
               o = int'(column_drop[i]);
               if (o < 0) begin
                  column_drop[i] = cwo_pkg::offset_type'(o + 1);
                  moved = 1'b1;
               end else if (o < h) begin
                  dy = (o < SLOW_ROWS) ? o + 1 : int'(model_step);
                  if (o + dy >= h) dy = h - o;
                  column_drop[i] = cwo_pkg::offset_type'(o + dy);
                  moved = 1'b1;
               end
            end
            ans.melt_done = !moved;
         end
         cwo_pkg::MODE_LOOKUP: begin
            o = int'(column_drop[col]);
            if (int'(row) >= h || int'(row) < o) begin
               ans.is_end = 1'b1;
               ans.src_row = row;
            end else begin
               ans.src_row = cwo_pkg::ROW_W'(int'(row) - ((o < 0) ? 0 : o));
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   // Sends one item in bursts with random gaps, and predicts its answer on acceptance.
   task automatic send_item(input logic [cwo_pkg::MODE_W-1:0] mode,
         input logic [cwo_pkg::COLUMN_W-1:0] col, input logic [cwo_pkg::ROW_W-1:0] row,
         input logic [cwo_pkg::RANDOM_W-1:0] rnd);
      int gap;
      melt_answer_type ans;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start <= 1'b1;
      req_mode <= mode;
      req_column <= col;
      req_row <= row;
      req_random_value <= rnd;
      @(posedge clock);
      while (busy) @(posedge clock);
      ans = advance_melt(mode, col, row, rnd);
      answers_due.push_back(ans);
      if (mode == cwo_pkg::MODE_TICK) melt_finished = ans.melt_done;
      items_sent++;
   endtask

   // Writes one register once the block has answered everything.
   task automatic write_reg(input logic [cwo_pkg::INDEX_W-1:0] index, input int value);
      start <= 1'b0;
      burst_left = 0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= cwo_pkg::HEIGHT_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         cwo_pkg::CSR_SCREEN_HEIGHT: model_height = cwo_pkg::HEIGHT_W'(value);
         cwo_pkg::CSR_COLUMN_COUNT:  model_count = cwo_pkg::COUNT_W'(value);
         cwo_pkg::CSR_FAST_STEP:     model_step = cwo_pkg::STEP_W'(value);
         default: ;
      endcase
   endtask

   task automatic set_config(input int height, input int count, input int step);
      write_reg(cwo_pkg::CSR_SCREEN_HEIGHT, height);
      write_reg(cwo_pkg::CSR_COLUMN_COUNT, count);
      write_reg(cwo_pkg::CSR_FAST_STEP, step);
   endtask

   // Seeds columns 0 upward in order, as a wipe start does.
   task automatic seed_columns(input int count);
      for (int c = 0; c < count; c++) begin
         send_item(cwo_pkg::MODE_SEED, cwo_pkg::COLUMN_W'(c), cwo_pkg::ROW_W'($urandom()),
                   cwo_pkg::RANDOM_W'($urandom()));
      end
   endtask

   // Looks up a pixel, mostly near the column's edge or inside the screen.
   task automatic random_lookup(input int span);
      int c;
      int r;
      int o;
      int pick;
      if ($urandom_range(0, 4) == 0) c = $urandom_range(0, COLUMN_SLOTS - 1);
      else c = $urandom_range(0, span - 1);
      o = int'(column_drop[c]);
      pick = $urandom_range(0, 2);
      if (pick == 0) r = o + int'($urandom_range(0, 4)) - 2;
      else if (pick == 1) r = $urandom_range(0, int'(model_height) - 1);
      else r = $urandom_range(0, ROW_MAX);
      if (r < 0) r = 0;
      if (r > ROW_MAX) r = ROW_MAX;
      send_item(cwo_pkg::MODE_LOOKUP, cwo_pkg::COLUMN_W'(c), cwo_pkg::ROW_W'(r),
                cwo_pkg::RANDOM_W'($urandom()));
   endtask

   // Ticks until no column moves or the tick budget runs out, with lookups in between.
   task automatic melt_until_done(input int max_ticks, input int span);
      int t;
      t = 0;
      melt_finished = 1'b0;
      while (!melt_finished && t < max_ticks) begin
         send_item(cwo_pkg::MODE_TICK, cwo_pkg::COLUMN_W'($urandom()),
                   cwo_pkg::ROW_W'($urandom()), cwo_pkg::RANDOM_W'($urandom()));
         t++;
         repeat ($urandom_range(0, 2)) random_lookup(span);
      end
   endtask

   // Every column gets an offset under the reset settings, then one full melt runs.
   task automatic test_fill_at_reset_values();
      seed_columns(COLUMN_SLOTS);
      // Rows on both sides of the default screen height.
      send_item(cwo_pkg::MODE_LOOKUP, cwo_pkg::COLUMN_W'(5), cwo_pkg::ROW_W'(DEFAULT_H - 1),
                '0);
      send_item(cwo_pkg::MODE_LOOKUP, cwo_pkg::COLUMN_W'(5), cwo_pkg::ROW_W'(DEFAULT_H), '0);
      melt_until_done(64, DEFAULT_N);
   endtask

   // Seed clamping at both ends, the ignored mode and rows past the screen.
   task automatic test_seed_clamps();
      set_config(24, 4, 3);
      // Deepest start, then a chain that tries to go below the floor.
      send_item(cwo_pkg::MODE_SEED, '0, '0, 8'd255);
      send_item(cwo_pkg::MODE_SEED, cwo_pkg::COLUMN_W'(1), '0, 8'd0);
      send_item(cwo_pkg::MODE_SEED, cwo_pkg::COLUMN_W'(2), '0, 8'd2);
      send_item(cwo_pkg::MODE_SEED, cwo_pkg::COLUMN_W'(3), '0, 8'd1);
      send_item(cwo_pkg::MODE_LOOKUP, '0, '0, '0);
      send_item(cwo_pkg::MODE_LOOKUP, '0, cwo_pkg::ROW_W'(23), '0);
      send_item(cwo_pkg::MODE_LOOKUP, '0, cwo_pkg::ROW_W'(24), '0);
      send_item(cwo_pkg::MODE_LOOKUP, '1, '1, '1);
      send_item(MODE_UNUSED, '1, '1, '1);
      // Shallowest start, then a chain that tries to rise above zero.
      send_item(cwo_pkg::MODE_SEED, '0, '1, 8'd16);
      send_item(cwo_pkg::MODE_SEED, cwo_pkg::COLUMN_W'(1), '1, 8'd2);
      send_item(cwo_pkg::MODE_SEED, cwo_pkg::COLUMN_W'(2), '1, 8'd3);
      send_item(cwo_pkg::MODE_SEED, cwo_pkg::COLUMN_W'(3), '1, 8'd1);
      melt_until_done(16, 4);
   endtask

   // Random settings, each followed by a well-formed wipe and some unordered items.
   task automatic test_random_wipes();
      int target;
      int k;
      int pick;
      int h;
      int n;
      int s;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         k = $urandom_range(1, 24);
         pick = $urandom_range(0, 9);
         h = (pick == 0) ? 1 : (pick == 1) ? HEIGHT_TOP : $urandom_range(16, 128);
         pick = $urandom_range(0, 9);
         n = (pick == 0) ? COLUMN_SLOTS : (pick == 1) ? 1 : k;
         pick = $urandom_range(0, 9);
         s = (pick == 0) ? 1 : (pick == 1) ? STEP_TOP : $urandom_range(6, 40);
         set_config(h, n, s);
         seed_columns(k);
         melt_until_done(48, k);
         repeat ($urandom_range(4, 12)) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
               random_lookup(k);
            end else if (pick < 8) begin
               send_item(cwo_pkg::MODE_SEED, cwo_pkg::COLUMN_W'($urandom()),
                         cwo_pkg::ROW_W'($urandom()), cwo_pkg::RANDOM_W'($urandom()));
            end else begin
               send_item((pick == 8) ? MODE_UNUSED : cwo_pkg::MODE_TICK,
                         cwo_pkg::COLUMN_W'($urandom()), cwo_pkg::ROW_W'($urandom()),
                         cwo_pkg::RANDOM_W'($urandom()));
            end
         end
      end
   endtask

   // Large and smallest register values, and a column count past the storage.
   task automatic test_register_extremes();
      set_config(HEIGHT_TOP, COLUMN_SLOTS, STEP_TOP);
      seed_columns(32);
      melt_until_done(64, COLUMN_SLOTS);
      send_item(cwo_pkg::MODE_LOOKUP, '0, cwo_pkg::ROW_W'(ROW_MAX), '0);
      set_config(1, (1 << cwo_pkg::COUNT_W) - 1, 1);
      send_item(cwo_pkg::MODE_TICK, '0, '0, '0);
      seed_columns(8);
      melt_until_done(32, 8);
      send_item(cwo_pkg::MODE_LOOKUP, '0, '0, '0);
      send_item(cwo_pkg::MODE_LOOKUP, '0, cwo_pkg::ROW_W'(1), '0);
      set_config(HEIGHT_TOP, 1, 1);
      seed_columns(1);
      melt_until_done(24, 1);
   endtask

   // Each answer is checked against the oldest prediction.
   always @(posedge clock) begin : check_answers
      melt_answer_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (answers_due.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT) $error("answer with no item outstanding");
         end else begin
            want = answers_due.pop_front();
            if (rsp_source_is_end !== want.is_end) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $error("source_is_end: expected %0d, got %0d", want.is_end,
                         rsp_source_is_end);
            end
            if (rsp_source_row !== want.src_row) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $error("source_row: expected %0d, got %0d", want.src_row, rsp_source_row);
            end
            if (rsp_melt_done !== want.melt_done) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $error("melt_done: expected %0d, got %0d", want.melt_done, rsp_melt_done);
            end
         end
      end
   end

   // Guard against a block that stops answering.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_column_melt_wipe_offsets NOT OK");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_mode = cwo_pkg::MODE_SEED;
      req_column = '0;
      req_row = '0;
      req_random_value = '0;
      csr_we = 1'b0;
      csr_index = cwo_pkg::CSR_SCREEN_HEIGHT;
      csr_wdata = '0;
      cycles = 0;
      errors = 0;
      items_sent = 0;
      burst_left = 0;
      melt_finished = 1'b0;
      last_seed = '0;
      model_height = cwo_pkg::HEIGHT_W'(DEFAULT_H);
      model_count = cwo_pkg::COUNT_W'(DEFAULT_N);
      model_step = cwo_pkg::STEP_W'(DEFAULT_STEP);
      foreach (column_drop[i]) column_drop[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fill_at_reset_values();
      test_seed_clamps();
      test_random_wipes();
      test_register_extremes();

      // Let the last answers arrive, then watch for stray ones.
      start <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("tb_column_melt_wipe_offsets OK");
      end else begin
         $display("tb_column_melt_wipe_offsets NOT OK");
      end
      $finish;
   end

endmodule
